/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RSD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define RSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

/* hw/rtl/rsd_pkg.sv */
// Types and constants of the random subset draw block.
package rsd_pkg;

   localparam int POOL_SIZE_DEF = 49;
   localparam int MIN_PICKS     = 6;
   localparam int VAL_W         = 6;
   localparam int WORD_W        = 31;
   localparam int DIV_CNT_W     = 5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SELECT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic sel_step;
      logic emit_step;
      logic refill;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic sel_found;
      logic round_end;
      logic emit_last;
   } status_type;

endpackage

/* hw/rtl/rsd_ctrl.sv */
// Sequencer of the random subset draw: divide, select, emit.
module rsd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  rsd_pkg::status_type status,
   output rsd_pkg::cmd_type    cmd
);

   rsd_pkg::state_type state_ff;
   rsd_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rsd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         rsd_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = rsd_pkg::ST_DIVIDE;
            end
         end
         rsd_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = rsd_pkg::ST_SELECT;
            end
         end
         rsd_pkg::ST_SELECT: begin
            cmd.sel_step = 1'b1;
            if (status.sel_found) begin
               state_in = status.round_end ? rsd_pkg::ST_EMIT : rsd_pkg::ST_IDLE;
            end
         end
         rsd_pkg::ST_EMIT: begin
            cmd.emit_step = 1'b1;
            if (status.emit_last) begin
               cmd.refill = 1'b1;
               state_in   = rsd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rsd_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != rsd_pkg::ST_IDLE);

endmodule

/* hw/rtl/rsd_datapath.sv */
// Datapath: bit-serial remainder, drawn-number mask scan, result register.
module rsd_datapath #(
   parameter int POOL_SIZE = rsd_pkg::POOL_SIZE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [rsd_pkg::WORD_W-1:0]        req_random_word,
   input  logic                              csr_valid,
   input  logic [rsd_pkg::VAL_W-1:0]         csr_pick_count,
   input  rsd_pkg::cmd_type                  cmd,
   output rsd_pkg::status_type               status,
   output logic                              rsp_valid,
   output logic [rsd_pkg::VAL_W-1:0]         rsp_number,
   output logic [rsd_pkg::VAL_W-1:0]         rsp_rank,
   output logic                              rsp_last
);

   localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam logic [rsd_pkg::VAL_W-1:0] POOL_V  = rsd_pkg::VAL_W'(POOL_SIZE);
   localparam logic [rsd_pkg::VAL_W-1:0] MIN_V   = rsd_pkg::VAL_W'(rsd_pkg::MIN_PICKS);
   localparam logic [rsd_pkg::DIV_CNT_W-1:0] DIV_END =
      rsd_pkg::DIV_CNT_W'(rsd_pkg::WORD_W - 1);

   logic [rsd_pkg::VAL_W-1:0]     pick_count_ff;
   logic [rsd_pkg::VAL_W-1:0]     drawn_count_ff, drawn_count_in;
   logic [POOL_SIZE-1:0]          used_ff, used_in;
   logic [rsd_pkg::WORD_W-1:0]    word_ff, word_in;
   logic [rsd_pkg::VAL_W-1:0]     rem_ff, rem_in;
   logic [rsd_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [IDX_W-1:0]              num_ff, num_in;
   logic [IDX_W-1:0]              zcount_ff, zcount_in;
   logic [rsd_pkg::VAL_W-1:0]     rank_ff, rank_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rsd_pkg::VAL_W-1:0]     rsp_number_ff, rsp_number_in;
   logic [rsd_pkg::VAL_W-1:0]     rsp_rank_ff, rsp_rank_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic [rsd_pkg::VAL_W-1:0]     remaining;
   logic [rsd_pkg::VAL_W:0]       trial;
   logic [rsd_pkg::VAL_W-1:0]     eff_count;
   logic [rsd_pkg::VAL_W-1:0]     drawn_next;
   logic [rsd_pkg::VAL_W-1:0]     rank_next;
   logic                          cur_used;
   logic                          hit;

   // Effective count: raise to the minimum, then cap at the pool size.
   always_comb begin
      eff_count = (pick_count_ff < MIN_V) ? MIN_V : pick_count_ff;
      if (eff_count > POOL_V) begin
         eff_count = POOL_V;
      end
   end

   assign remaining  = POOL_V - drawn_count_ff;
   assign trial      = {rem_ff, word_ff[rsd_pkg::WORD_W-1]};
   assign cur_used   = used_ff[num_ff];
   assign hit        = !cur_used && (rsd_pkg::VAL_W'(zcount_ff) == rem_ff);
   assign drawn_next = drawn_count_ff + rsd_pkg::VAL_W'(1);
   assign rank_next  = rank_ff + rsd_pkg::VAL_W'(1);

   assign status.div_last  = (div_cnt_ff == DIV_END);
   assign status.sel_found = hit;
   assign status.round_end = (drawn_next >= eff_count);
   // Stop the scan at the highest drawn number.
   assign status.emit_last = cur_used && (rank_next == drawn_count_ff);

   always_comb begin
      word_in        = word_ff;
      rem_in         = rem_ff;
      div_cnt_in     = div_cnt_ff;
      num_in         = num_ff;
      zcount_in      = zcount_ff;
      rank_in        = rank_ff;
      used_in        = used_ff;
      drawn_count_in = drawn_count_ff;
      rsp_valid_in   = 1'b0;
      rsp_number_in  = rsp_number_ff;
      rsp_rank_in    = rsp_rank_ff;
      rsp_last_in    = rsp_last_ff;

      if (cmd.load) begin
         word_in    = req_random_word;
         rem_in     = '0;
         div_cnt_in = '0;
         num_in     = '0;
         zcount_in  = '0;
      end

      // One quotient bit per cycle; the remainder stays below the divisor.
      if (cmd.div_step) begin
         word_in    = {word_ff[rsd_pkg::WORD_W-2:0], 1'b0};
         div_cnt_in = div_cnt_ff + rsd_pkg::DIV_CNT_W'(1);
         if (trial >= {1'b0, remaining}) begin
            rem_in = rsd_pkg::VAL_W'(trial - {1'b0, remaining});
         end else begin
            rem_in = trial[rsd_pkg::VAL_W-1:0];
         end
      end

      // Walk all numbers, counting undrawn ones, up to the chosen one.
      if (cmd.sel_step) begin
         if (hit) begin
            used_in[num_ff] = 1'b1;
            drawn_count_in  = drawn_next;
            num_in          = '0;
            rank_in         = '0;
         end else begin
            num_in = num_ff + IDX_W'(1);
            if (!cur_used) begin
               zcount_in = zcount_ff + IDX_W'(1);
            end
         end
      end

      // Drawn numbers come out of the mask already in ascending order.
      if (cmd.emit_step) begin
         num_in = num_ff + IDX_W'(1);
         if (cur_used) begin
            rsp_valid_in  = 1'b1;
            rsp_number_in = rsd_pkg::VAL_W'(num_ff) + rsd_pkg::VAL_W'(1);
            rsp_rank_in   = rank_next;
            rsp_last_in   = (rank_next == drawn_count_ff);
            rank_in       = rank_next;
         end
      end

      if (cmd.refill) begin
         used_in        = '0;
         drawn_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pick_count_ff  <= MIN_V;
         drawn_count_ff <= '0;
         used_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            pick_count_ff <= csr_pick_count;
         end
         drawn_count_ff <= drawn_count_in;
         used_ff        <= used_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff       <= word_in;
      rem_ff        <= rem_in;
      div_cnt_ff    <= div_cnt_in;
      num_ff        <= num_in;
      zcount_ff     <= zcount_in;
      rank_ff       <= rank_in;
      rsp_number_ff <= rsp_number_in;
      rsp_rank_ff   <= rsp_rank_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_number = rsp_number_ff;
   assign rsp_rank   = rsp_rank_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

/* hw/rtl/random_subset_draw_sorted.sv */
// Top level of the random subset draw with sorted output.
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   ---------------------------
//   request   req_random_word                         start & !busy
//   response  rsp_number, rsp_rank, rsp_last          rsp_valid, one-cycle strobe
//   config    csr_pick_count                          csr_valid & csr_ready
//
// A draw runs the bit-serial remainder over the whole random word, then scans
// pool numbers up to the chosen one, with busy high throughout.
// The draw that ends a round adds a mask scan up to the highest drawn
// number; results come as strobes, with gaps for numbers not drawn,
// and busy drops with the last.
// Reset is synchronous; the pool mask clears at once, no clearing pass.
// Results cannot be stalled; csr_ready is always high.
module random_subset_draw_sorted #(
   parameter int POOL_SIZE = rsd_pkg::POOL_SIZE_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [rsd_pkg::WORD_W-1:0] req_random_word,
   output logic                       rsp_valid,
   output logic [rsd_pkg::VAL_W-1:0]  rsp_number,
   output logic [rsd_pkg::VAL_W-1:0]  rsp_rank,
   output logic                       rsp_last,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [rsd_pkg::VAL_W-1:0]  csr_pick_count
);

   rsd_pkg::cmd_type    cmd;
   rsd_pkg::status_type status;

   assign csr_ready = 1'b1;

   rsd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   rsd_datapath #(
      .POOL_SIZE (POOL_SIZE)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_random_word (req_random_word),
      .csr_valid       (csr_valid),
      .csr_pick_count  (csr_pick_count),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_number      (rsp_number),
      .rsp_rank        (rsp_rank),
      .rsp_last        (rsp_last)
   );

endmodule

/* hw/rtl/rsd_checker.sv */
// Port-level checks of the random subset draw, bound to the top level.
`include "assert_macros.svh"

module rsd_checker #(
   parameter int POOL_SIZE = rsd_pkg::POOL_SIZE_DEF
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_valid,
   input logic [rsd_pkg::VAL_W-1:0] rsp_number,
   input logic [rsd_pkg::VAL_W-1:0] rsp_rank,
   input logic                      rsp_last
);

   localparam logic [rsd_pkg::VAL_W-1:0] MAX_NUM = rsd_pkg::VAL_W'(POOL_SIZE);

   // An accepted item keeps the block busy for at least the next cycle.
   `RSD_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

   // The round's final item arrives as the block goes idle.
   `RSD_ASSERT_IMPLY(a_last_idle, clock, reset, rsp_valid && rsp_last, !busy)

   // Any other item of the round comes while the scan is still running.
   `RSD_ASSERT_IMPLY(a_mid_busy, clock, reset, rsp_valid && !rsp_last, busy)

   `RSD_ASSERT_IMPLY(a_number_range, clock, reset, rsp_valid, rsp_number != 0 && rsp_number <= MAX_NUM)

   // Back-to-back items of one round ascend in number and step the rank by one.
   `RSD_ASSERT_IMPLY(a_ascending, clock, reset, rsp_valid && $past(rsp_valid) && !$past(rsp_last), rsp_number > $past(rsp_number) && rsp_rank == $past(rsp_rank) + 1'b1)

endmodule

bind random_subset_draw_sorted rsd_checker #(
   .POOL_SIZE (POOL_SIZE)
) u_rsd_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_number (rsp_number),
   .rsp_rank   (rsp_rank),
   .rsp_last   (rsp_last)
);

/* test/testbench.sv */
// Self-checking testbench for the random subset draw with sorted output.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL       = rsd_pkg::POOL_SIZE_DEF;
   localparam int CYCLE_CAP  = 1_000_000;
   localparam int QUIET_GAP  = 3 * POOL + 40;

   class draw_scoreboard;
      typedef struct {
         logic [rsd_pkg::VAL_W-1:0] number;
         logic [rsd_pkg::VAL_W-1:0] rank;
         logic                      last;
      } pick_type;

      logic [rsd_pkg::VAL_W-1:0] pool [POOL];
      logic [rsd_pkg::VAL_W-1:0] picks [POOL];
      int unsigned               drawn;
      logic [rsd_pkg::VAL_W-1:0] pick_count;
      pick_type                  pending_picks [$];
      int                        errors;

      function new();
         pick_count = 6'd6;
         errors     = 0;
         refill();
      endfunction

      function void refill();
         for (int i = 0; i < POOL; i++) pool[i] = rsd_pkg::VAL_W'(i + 1);
         drawn = 0;
      endfunction

      function void set_pick_count(logic [rsd_pkg::VAL_W-1:0] value);
         pick_count = value;
      endfunction

      // Remove the chosen pool entry, insert it in order, emit at round end.
      function void note_draw(logic [rsd_pkg::WORD_W-1:0] word);
         int unsigned               remaining;
         int unsigned               idx;
         int unsigned               pos;
         int unsigned               target;
         logic [rsd_pkg::VAL_W-1:0] chosen;
         pick_type                  res;
         if (drawn >= POOL) refill();
         remaining = POOL - drawn;
         idx       = {1'b0, word} % remaining;
         chosen    = pool[idx];
         for (int unsigned j = idx; j + 1 < remaining; j++) pool[j] = pool[j + 1];
         pos = drawn;
         while (pos > 0 && picks[pos - 1] > chosen) begin
            picks[pos] = picks[pos - 1];
            pos--;
         end
         picks[pos] = chosen;
         drawn++;
         target = pick_count;
         if (target < rsd_pkg::MIN_PICKS) target = rsd_pkg::MIN_PICKS;
         if (target > POOL) target = POOL;
         if (drawn < target) return;
         for (int unsigned j = 0; j < drawn; j++) begin
            res.number = picks[j];
            res.rank   = rsd_pkg::VAL_W'(j + 1);
            res.last   = (j + 1 == drawn);
            pending_picks.push_back(res);
         end
         refill();
      endfunction

      task report_mismatch(string msg);
         errors++;
         $display("[%0t] mismatch: %s", $realtime, msg);
      endtask

      task check_result(logic [rsd_pkg::VAL_W-1:0] number, logic [rsd_pkg::VAL_W-1:0] rank,
                        logic last);
         pick_type want;
         if (pending_picks.size() == 0) begin
            report_mismatch($sformatf("unexpected result number=%0d rank=%0d last=%0b",
                                      number, rank, last));
            return;
         end
         want = pending_picks.pop_front();
         if (number !== want.number)
            report_mismatch($sformatf("number %0d, want %0d (rank %0d)",
                                      number, want.number, want.rank));
         if (rank !== want.rank)
            report_mismatch($sformatf("rank %0d, want %0d", rank, want.rank));
         if (last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b (rank %0d)",
                                      last, want.last, want.rank));
      endtask
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [rsd_pkg::WORD_W-1:0] req_random_word = '0;
   logic                       rsp_valid;
   logic [rsd_pkg::VAL_W-1:0]  rsp_number;
   logic [rsd_pkg::VAL_W-1:0]  rsp_rank;
   logic                       rsp_last;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [rsd_pkg::VAL_W-1:0]  csr_pick_count = '0;

   draw_scoreboard sb = new();
   int unsigned    cycles = 0;

   random_subset_draw_sorted #(.POOL_SIZE(POOL)) DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_random_word(req_random_word),
      .rsp_valid      (rsp_valid),
      .rsp_number     (rsp_number),
      .rsp_rank       (rsp_rank),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_pick_count (csr_pick_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("testbench failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_number, rsp_rank, rsp_last);
   end

   // Hold start high from here on until an idle cycle lowers it.
   task automatic send_draw(logic [rsd_pkg::WORD_W-1:0] word, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_random_word <= word;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_draw(word);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending_picks.size() != 0) @(posedge clock);
   endtask

   // Drain results, then let a draw that emits nothing finish before a write.
   task automatic write_pick_count(logic [rsd_pkg::VAL_W-1:0] value);
      wait_drained();
      repeat (QUIET_GAP) @(posedge clock);
      csr_valid      <= 1'b1;
      csr_pick_count <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.set_pick_count(value);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [rsd_pkg::WORD_W-1:0] random_word();
      case ($urandom_range(3))
         0: return rsd_pkg::WORD_W'($urandom);
         1: return rsd_pkg::WORD_W'($urandom_range(0, 2 * POOL));
         2: return {rsd_pkg::WORD_W{1'b1}} - rsd_pkg::WORD_W'($urandom_range(0, 2 * POOL));
         default: return {1'b1, (rsd_pkg::WORD_W - 1)'($urandom)};
      endcase
   endfunction

   task automatic run_phase(logic [rsd_pkg::VAL_W-1:0] count, int items, int idle_pct);
      write_pick_count(count);
      for (int i = 0; i < items; i++) begin
         if ($urandom_range(49) == 0) wait_drained();
         send_draw(random_word(), idle_pct);
      end
   endtask

   initial begin
      logic [rsd_pkg::WORD_W-1:0] directed [$];
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Extremes of the word, then all-lowest picks, then top-of-pool picks.
      directed = '{31'd0, 31'd48, 31'h7FFF_FFFF, 31'd45, 31'h2AAA_AAAA, 31'h5555_5555,
                   31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0,
                   31'd48, 31'd47, 31'd46, 31'd45, 31'd44, 31'd43};
      write_pick_count(6'd6);
      foreach (directed[i]) send_draw(directed[i], 0);

      // Sender idles a third of the time.
      run_phase(6'd0, 40, 33);
      run_phase(6'd63, 2 * POOL, 33);
      // Lower the count mid-round: the next draw flushes the whole list.
      run_phase(6'd49, 20, 33);
      run_phase(6'd5, 30, 50);
      // Sender idles half the time.
      run_phase(6'd50, POOL, 50);
      run_phase(rsd_pkg::VAL_W'($urandom_range(6, POOL)), 40, 50);
      // No idling.
      run_phase(rsd_pkg::VAL_W'($urandom_range(6, 20)), 40, 0);
      run_phase(6'd7, 30, 0);

      wait_drained();
      repeat (QUIET_GAP) @(posedge clock);
      if (sb.errors == 0 && sb.pending_picks.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end
endmodule
